>>> sv/bpa_pkg.sv
// shared types, constants and codes of the buddy page allocator
// no dependencies; used by every module of the block but bpa_ram
`default_nettype none

package bpa_pkg;

  localparam int NUM_FRAMES_DEF  = 1024;
  localparam int ORDER_COUNT_DEF = 11;
  localparam int FRAME_BYTES_DEF = 4096;

  localparam logic [31:0] REGION_RESET = 32'h1000_0000;

  // frame state code: order of a free block head, or one of two markers
  localparam int STATE_W = 5;
  localparam logic [STATE_W-1:0] FS_FREE_PART = 5'd30;
  localparam logic [STATE_W-1:0] FS_ALLOCATED = 5'd31;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_OOM          = 2'd1;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [1:0] ST_RANGE        = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [22:0] size_bytes;
    logic [31:0] address;
  } bpa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [10:0] block_frames;
  } bpa_rsp_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SRCH,
    CMD_SPL_RD,
    CMD_SPL_POP,
    CMD_SPL_UP,
    CMD_SPL_LOW,
    CMD_POP_RD,
    CMD_POP,
    CMD_MARK,
    CMD_FS_RD,
    CMD_FREE_HEAD,
    CMD_FREE_PART,
    CMD_PUSH,
    CMD_MRG_RD,
    CMD_MRG_NTOP,
    CMD_WALK_RD,
    CMD_WALK_NXT,
    CMD_FND_RD,
    CMD_FND_LINK,
    CMD_FND_PUSH,
    CMD_RESULT
  } bpa_cmd_t;

  // which list head the datapath looks at this cycle
  typedef enum logic [1:0] {
    HS_K,
    HS_E,
    HS_M,
    HS_M1
  } bpa_hsel_t;

  typedef struct packed {
    bpa_cmd_t   cmd;
    bpa_hsel_t  hsel;
    logic [1:0] res_status;
  } bpa_ctl_t;

  typedef struct packed {
    logic too_big;
    logic is_free;
    logic below_base;
    logic k_at_end;
    logic head_empty;
    logic k_gt_e;
    logic mark_more;
    logic part_more;
    logic range_bad;
    logic fs_alloc;
    logic merge_ok;
    logic walk_more;
    logic walk_hit;
    logic clear_last;
    logic out_free;
  } bpa_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SPLCHK,
    S_SPLPOP,
    S_SPLUP,
    S_SPLLOW,
    S_POP,
    S_MARK,
    S_RCHK,
    S_FSCHK,
    S_PART,
    S_MCHK,
    S_MNTOP,
    S_WALK,
    S_WNXT,
    S_FLINK,
    S_FPUSH,
    S_RES_OK,
    S_RES_OOM,
    S_RES_AFREE,
    S_RES_RANGE
  } bpa_state_t;

endpackage

`default_nettype wire

>>> sv/bpa_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/bpa_ctrl.sv
// sequencer of the buddy page allocator: walks each request through its steps
// depends on bpa_pkg for state, command and status types
`default_nettype none

module bpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire bpa_pkg::bpa_stat_t stat,
  output logic                   in_ready,
  output bpa_pkg::bpa_ctl_t      ctl
);

  bpa_pkg::bpa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ctl.cmd        = bpa_pkg::CMD_NONE;
    ctl.hsel       = bpa_pkg::HS_K;
    ctl.res_status = bpa_pkg::ST_OK;
    in_ready       = 1'b0;
    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        ctl.cmd = bpa_pkg::CMD_CLEAR;
        if (stat.clear_last) state_nxt = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd   = bpa_pkg::CMD_LOAD;
          state_nxt = bpa_pkg::S_DISPATCH;
        end
      end
      bpa_pkg::S_DISPATCH: begin
        if (!stat.is_free) begin
          state_nxt = stat.too_big ? bpa_pkg::S_RES_OOM : bpa_pkg::S_SRCH;
        end else begin
          state_nxt = (stat.too_big || stat.below_base) ? bpa_pkg::S_RES_RANGE
                                                        : bpa_pkg::S_RCHK;
        end
      end
      bpa_pkg::S_SRCH: begin
        priority if (stat.k_at_end) begin
          state_nxt = bpa_pkg::S_RES_OOM;
        end else if (!stat.head_empty) begin
          state_nxt = bpa_pkg::S_SPLCHK;
        end else begin
          ctl.cmd = bpa_pkg::CMD_SRCH;
        end
      end
      bpa_pkg::S_SPLCHK: begin
        // k equals e on the final pop, so the head at k is the head at e
        if (stat.k_gt_e) begin
          ctl.cmd   = bpa_pkg::CMD_SPL_RD;
          state_nxt = bpa_pkg::S_SPLPOP;
        end else begin
          ctl.cmd   = bpa_pkg::CMD_POP_RD;
          state_nxt = bpa_pkg::S_POP;
        end
      end
      bpa_pkg::S_SPLPOP: begin
        ctl.cmd   = bpa_pkg::CMD_SPL_POP;
        state_nxt = bpa_pkg::S_SPLUP;
      end
      bpa_pkg::S_SPLUP: begin
        ctl.cmd   = bpa_pkg::CMD_SPL_UP;
        state_nxt = bpa_pkg::S_SPLLOW;
      end
      bpa_pkg::S_SPLLOW: begin
        ctl.cmd   = bpa_pkg::CMD_SPL_LOW;
        state_nxt = bpa_pkg::S_SPLCHK;
      end
      bpa_pkg::S_POP: begin
        ctl.cmd   = bpa_pkg::CMD_POP;
        state_nxt = bpa_pkg::S_MARK;
      end
      bpa_pkg::S_MARK: begin
        if (stat.mark_more) ctl.cmd = bpa_pkg::CMD_MARK;
        else state_nxt = bpa_pkg::S_RES_OK;
      end
      bpa_pkg::S_RCHK: begin
        if (stat.range_bad) begin
          state_nxt = bpa_pkg::S_RES_RANGE;
        end else begin
          ctl.cmd   = bpa_pkg::CMD_FS_RD;
          state_nxt = bpa_pkg::S_FSCHK;
        end
      end
      bpa_pkg::S_FSCHK: begin
        if (!stat.fs_alloc) begin
          state_nxt = bpa_pkg::S_RES_AFREE;
        end else begin
          ctl.cmd   = bpa_pkg::CMD_FREE_HEAD;
          state_nxt = bpa_pkg::S_PART;
        end
      end
      bpa_pkg::S_PART: begin
        ctl.hsel = bpa_pkg::HS_E;
        if (stat.part_more) begin
          ctl.cmd = bpa_pkg::CMD_FREE_PART;
        end else begin
          ctl.cmd   = bpa_pkg::CMD_PUSH;
          state_nxt = bpa_pkg::S_MCHK;
        end
      end
      bpa_pkg::S_MCHK: begin
        ctl.hsel = bpa_pkg::HS_M;
        if (stat.merge_ok) begin
          ctl.cmd   = bpa_pkg::CMD_MRG_RD;
          state_nxt = bpa_pkg::S_MNTOP;
        end else begin
          state_nxt = bpa_pkg::S_RES_OK;
        end
      end
      bpa_pkg::S_MNTOP: begin
        ctl.cmd   = bpa_pkg::CMD_MRG_NTOP;
        state_nxt = bpa_pkg::S_WALK;
      end
      bpa_pkg::S_WALK: begin
        priority if (!stat.walk_more) begin
          state_nxt = bpa_pkg::S_RES_OK;
        end else if (stat.walk_hit) begin
          ctl.cmd   = bpa_pkg::CMD_FND_RD;
          state_nxt = bpa_pkg::S_FLINK;
        end else begin
          ctl.cmd   = bpa_pkg::CMD_WALK_RD;
          state_nxt = bpa_pkg::S_WNXT;
        end
      end
      bpa_pkg::S_WNXT: begin
        ctl.cmd   = bpa_pkg::CMD_WALK_NXT;
        state_nxt = bpa_pkg::S_WALK;
      end
      bpa_pkg::S_FLINK: begin
        ctl.hsel  = bpa_pkg::HS_M;
        ctl.cmd   = bpa_pkg::CMD_FND_LINK;
        state_nxt = bpa_pkg::S_FPUSH;
      end
      bpa_pkg::S_FPUSH: begin
        ctl.hsel  = bpa_pkg::HS_M1;
        ctl.cmd   = bpa_pkg::CMD_FND_PUSH;
        state_nxt = bpa_pkg::S_MCHK;
      end
      bpa_pkg::S_RES_OK, bpa_pkg::S_RES_OOM,
      bpa_pkg::S_RES_AFREE, bpa_pkg::S_RES_RANGE: begin
        unique case (state_r)
          bpa_pkg::S_RES_OOM:   ctl.res_status = bpa_pkg::ST_OOM;
          bpa_pkg::S_RES_AFREE: ctl.res_status = bpa_pkg::ST_ALREADY_FREE;
          bpa_pkg::S_RES_RANGE: ctl.res_status = bpa_pkg::ST_RANGE;
          default:              ctl.res_status = bpa_pkg::ST_OK;
        endcase
        // hold the result here until the output register has room
        if (stat.out_free) begin
          ctl.cmd   = bpa_pkg::CMD_RESULT;
          state_nxt = bpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/bpa_dp.sv
// datapath of the buddy page allocator: list heads, frame state and link rams,
// frame index shifter and result register; depends on bpa_pkg and bpa_ram
`default_nettype none

module bpa_dp #(
  parameter int NUM_FRAMES  = bpa_pkg::NUM_FRAMES_DEF,
  parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF,
  parameter int FRAME_BYTES = bpa_pkg::FRAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpa_pkg::bpa_ctl_t  ctl,
  input  wire bpa_pkg::bpa_req_t  in_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               out_ready,
  output bpa_pkg::bpa_stat_t      stat,
  output logic                    out_valid,
  output bpa_pkg::bpa_rsp_t       out_data
);

  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int HW  = $clog2(NUM_FRAMES + 1);
  localparam int OIW = $clog2(ORDER_COUNT);
  localparam int OW  = $clog2(ORDER_COUNT + 1);
  // frame size is a power of two, so the frame index is a shift
  localparam int FBW = $clog2(FRAME_BYTES);
  localparam int SW  = bpa_pkg::STATE_W;
  localparam logic [HW-1:0] EMPTY   = HW'(NUM_FRAMES);
  localparam logic [32:0]   NF33    = 33'(NUM_FRAMES);

  function automatic logic [32:0] pow2(input logic [OW-1:0] x);
    return 33'(1) << x;
  endfunction

  // reset image: one block per set bit of the frame count, lowest order first
  function automatic logic [SW-1:0] init_fs(input logic [FW-1:0] f);
    logic [SW-1:0] v;
    v = bpa_pkg::FS_FREE_PART;
    for (int j = 0; j < ORDER_COUNT; j++) begin
      if (((NUM_FRAMES >> j) & 1) == 1 && f == FW'(NUM_FRAMES & ((1 << j) - 1))) begin
        v = SW'(j);
      end
    end
    return v;
  endfunction

  logic [31:0]   base_r;
  logic          op_r, op_nxt;
  logic [OW-1:0] e_r, e_nxt;
  logic          too_big_r, too_big_nxt;
  logic          below_base_r, below_base_nxt;
  logic [OW-1:0] k_r, k_nxt;
  logic [OW-1:0] m_r, m_nxt;
  logic [HW-1:0] head_r [ORDER_COUNT];
  logic [FW-1:0] h_r, h_nxt;
  logic [FW-1:0] blk_r, blk_nxt;
  logic [HW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [FW-1:0] top_r, top_nxt;
  logic [HW-1:0] ntop_r, ntop_nxt;
  logic [HW-1:0] cur_r, cur_nxt;
  logic [FW-1:0] prev_r, prev_nxt;
  logic [FW-1:0] grp_r, grp_nxt;
  logic [HW-1:0] steps_r, steps_nxt;
  logic          out_valid_r, out_valid_nxt;
  bpa_pkg::bpa_rsp_t out_data_r, out_data_nxt;

  logic [ORDER_COUNT-1:0] fits;
  logic [OW-1:0]  e_calc;
  logic [OW-1:0]  hidx;
  logic [OW-1:0]  m1;
  logic [HW-1:0]  hval;
  logic           h_we;
  logic [HW-1:0]  h_wdata;
  logic [32:0]    up33;
  logic           up_in;
  logic [FW-1:0]  base_f;
  logic [32:0]    bud33;

  logic          fs_we, nl_we;
  logic [FW-1:0] fs_waddr, fs_raddr, nl_waddr, nl_raddr;
  logic [SW-1:0] fs_wdata, fs_q;
  logic [HW-1:0] nl_wdata, nl_q;

  bpa_ram #(.WIDTH(SW), .DEPTH(NUM_FRAMES)) u_fs_ram (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_q)
  );

  bpa_ram #(.WIDTH(HW), .DEPTH(NUM_FRAMES)) u_nl_ram (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(nl_raddr), .rdata(nl_q)
  );

  // order of the request: count of powers that are still too small
  always_comb begin
    e_calc = '0;
    for (int j = 0; j < ORDER_COUNT; j++) begin
      fits[j] = {17'd0, in_data.size_bytes} <= (40'(FRAME_BYTES) << j);
      e_calc  = e_calc + OW'(!fits[j]);
    end
  end

  assign m1 = m_r + OW'(1);

  always_comb begin
    unique case (ctl.hsel)
      bpa_pkg::HS_K:  hidx = k_r;
      bpa_pkg::HS_E:  hidx = e_r;
      bpa_pkg::HS_M:  hidx = m_r;
      bpa_pkg::HS_M1: hidx = m1;
      default:        hidx = k_r;
    endcase
  end

  assign hval   = (33'(hidx) < 33'(ORDER_COUNT)) ? head_r[hidx[OIW-1:0]] : EMPTY;
  assign up33   = 33'(h_r) + pow2(k_r);
  assign up_in  = up33 < NF33;
  assign base_f = FW'(grp_r << m1);
  assign bud33  = 33'(base_f) + pow2(m_r);

  always_comb begin
    stat.too_big    = too_big_r;
    stat.is_free    = op_r == bpa_pkg::OP_FREE;
    stat.below_base = below_base_r;
    stat.k_at_end   = 33'(k_r) == 33'(ORDER_COUNT);
    stat.head_empty = hval >= EMPTY;
    stat.k_gt_e     = k_r > e_r;
    stat.mark_more  = (33'(cnt_r) < pow2(e_r)) && (33'(blk_r) + 33'(cnt_r) < NF33);
    stat.part_more  = 33'(cnt_r) < pow2(e_r);
    stat.range_bad  = (33'(q_r) >= NF33) || (33'(q_r) + pow2(e_r) > NF33);
    stat.fs_alloc   = fs_q == bpa_pkg::FS_ALLOCATED;
    stat.merge_ok   = (33'(m_r) + 33'(1) < 33'(ORDER_COUNT)) && (hval < EMPTY);
    stat.walk_more  = (cur_r < EMPTY) && (steps_r < EMPTY);
    stat.walk_hit   = (cur_r[FW-1:0] != top_r) && ((cur_r[FW-1:0] >> m1) == grp_r);
    stat.clear_last = cnt_r == HW'(NUM_FRAMES - 1);
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    op_nxt         = op_r;
    e_nxt          = e_r;
    too_big_nxt    = too_big_r;
    below_base_nxt = below_base_r;
    k_nxt          = k_r;
    m_nxt          = m_r;
    h_nxt          = h_r;
    blk_nxt        = blk_r;
    cnt_nxt        = cnt_r;
    q_nxt          = q_r;
    top_nxt        = top_r;
    ntop_nxt       = ntop_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    grp_nxt        = grp_r;
    steps_nxt      = steps_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    h_we           = 1'b0;
    h_wdata        = hval;
    fs_we          = 1'b0;
    fs_waddr       = blk_r;
    fs_wdata       = bpa_pkg::FS_FREE_PART;
    fs_raddr       = q_r[FW-1:0];
    nl_we          = 1'b0;
    nl_waddr       = blk_r;
    nl_wdata       = hval;
    nl_raddr       = cur_r[FW-1:0];
    unique case (ctl.cmd)
      bpa_pkg::CMD_NONE: ;
      bpa_pkg::CMD_CLEAR: begin
        fs_we    = 1'b1;
        fs_waddr = cnt_r[FW-1:0];
        fs_wdata = init_fs(cnt_r[FW-1:0]);
        nl_we    = 1'b1;
        nl_waddr = cnt_r[FW-1:0];
        nl_wdata = EMPTY;
        cnt_nxt  = cnt_r + HW'(1);
      end
      bpa_pkg::CMD_LOAD: begin
        op_nxt         = in_data.op;
        e_nxt          = e_calc;
        too_big_nxt    = 33'(e_calc) == 33'(ORDER_COUNT);
        k_nxt          = e_calc;
        below_base_nxt = in_data.address < base_r;
        q_nxt          = (in_data.address - base_r) >> FBW;
      end
      bpa_pkg::CMD_SRCH: k_nxt = k_r + OW'(1);
      bpa_pkg::CMD_SPL_RD: begin
        h_nxt    = hval[FW-1:0];
        nl_raddr = hval[FW-1:0];
      end
      bpa_pkg::CMD_SPL_POP: begin
        h_we    = 1'b1;
        h_wdata = nl_q;
        k_nxt   = k_r - OW'(1);
      end
      bpa_pkg::CMD_SPL_UP: begin
        // head half gets its order, upper half goes on the list first
        fs_we    = 1'b1;
        fs_waddr = h_r;
        fs_wdata = SW'(k_r);
        if (up_in) begin
          nl_we    = 1'b1;
          nl_waddr = up33[FW-1:0];
          nl_wdata = hval;
          h_we     = 1'b1;
          h_wdata  = HW'(up33[FW-1:0]);
        end
      end
      bpa_pkg::CMD_SPL_LOW: begin
        nl_we    = 1'b1;
        nl_waddr = h_r;
        nl_wdata = hval;
        h_we     = 1'b1;
        h_wdata  = HW'(h_r);
        if (up_in) begin
          fs_we    = 1'b1;
          fs_waddr = up33[FW-1:0];
          fs_wdata = SW'(k_r);
        end
      end
      bpa_pkg::CMD_POP_RD: begin
        blk_nxt  = hval[FW-1:0];
        nl_raddr = hval[FW-1:0];
      end
      bpa_pkg::CMD_POP: begin
        h_we    = 1'b1;
        h_wdata = nl_q;
        cnt_nxt = '0;
      end
      bpa_pkg::CMD_MARK: begin
        fs_we    = 1'b1;
        fs_waddr = blk_r + cnt_r[FW-1:0];
        fs_wdata = bpa_pkg::FS_ALLOCATED;
        cnt_nxt  = cnt_r + HW'(1);
      end
      bpa_pkg::CMD_FS_RD: begin
        blk_nxt  = q_r[FW-1:0];
        fs_raddr = q_r[FW-1:0];
      end
      bpa_pkg::CMD_FREE_HEAD: begin
        fs_we    = 1'b1;
        fs_waddr = blk_r;
        fs_wdata = SW'(e_r);
        cnt_nxt  = HW'(1);
        m_nxt    = e_r;
      end
      bpa_pkg::CMD_FREE_PART: begin
        fs_we    = 1'b1;
        fs_waddr = blk_r + cnt_r[FW-1:0];
        fs_wdata = bpa_pkg::FS_FREE_PART;
        cnt_nxt  = cnt_r + HW'(1);
      end
      bpa_pkg::CMD_PUSH: begin
        nl_we    = 1'b1;
        nl_waddr = blk_r;
        nl_wdata = hval;
        h_we     = 1'b1;
        h_wdata  = HW'(blk_r);
      end
      bpa_pkg::CMD_MRG_RD: begin
        top_nxt   = hval[FW-1:0];
        prev_nxt  = hval[FW-1:0];
        grp_nxt   = hval[FW-1:0] >> m1;
        nl_raddr  = hval[FW-1:0];
        steps_nxt = '0;
      end
      bpa_pkg::CMD_MRG_NTOP: begin
        ntop_nxt = nl_q;
        cur_nxt  = nl_q;
      end
      bpa_pkg::CMD_WALK_RD: begin
        prev_nxt = cur_r[FW-1:0];
        nl_raddr = cur_r[FW-1:0];
      end
      bpa_pkg::CMD_WALK_NXT: begin
        cur_nxt   = nl_q;
        steps_nxt = steps_r + HW'(1);
      end
      bpa_pkg::CMD_FND_RD: nl_raddr = cur_r[FW-1:0];
      bpa_pkg::CMD_FND_LINK: begin
        // unlink the list top and the buddy found below it
        h_we = 1'b1;
        if (prev_r == top_r) begin
          h_wdata = nl_q;
        end else begin
          h_wdata  = ntop_r;
          nl_we    = 1'b1;
          nl_waddr = prev_r;
          nl_wdata = nl_q;
        end
        fs_we    = 1'b1;
        fs_waddr = base_f;
        fs_wdata = SW'(m1);
      end
      bpa_pkg::CMD_FND_PUSH: begin
        if (bud33 < NF33) begin
          fs_we    = 1'b1;
          fs_waddr = bud33[FW-1:0];
          fs_wdata = bpa_pkg::FS_FREE_PART;
        end
        nl_we    = 1'b1;
        nl_waddr = base_f;
        nl_wdata = hval;
        h_we     = 1'b1;
        h_wdata  = HW'(base_f);
        m_nxt    = m1;
      end
      bpa_pkg::CMD_RESULT: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = ctl.res_status;
        if (ctl.res_status == bpa_pkg::ST_OK) begin
          out_data_nxt.block_address = base_r + 32'(blk_r) * 32'(FRAME_BYTES);
          out_data_nxt.block_frames  = 11'(pow2(e_r));
        end else begin
          out_data_nxt.block_address = '0;
          out_data_nxt.block_frames  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= bpa_pkg::REGION_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < ORDER_COUNT; j++) begin
        head_r[j] <= (((NUM_FRAMES >> j) & 1) == 1) ? HW'(NUM_FRAMES & ((1 << j) - 1))
                                                    : EMPTY;
      end
    end else begin
      if (cfg_we) base_r <= cfg_wdata;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (h_we) head_r[hidx[OIW-1:0]] <= h_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    e_r          <= e_nxt;
    too_big_r    <= too_big_nxt;
    below_base_r <= below_base_nxt;
    k_r          <= k_nxt;
    m_r          <= m_nxt;
    h_r          <= h_nxt;
    blk_r        <= blk_nxt;
    q_r          <= q_nxt;
    top_r        <= top_nxt;
    ntop_r       <= ntop_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    grp_r        <= grp_nxt;
    steps_r      <= steps_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> sv/buddy_page_allocator_top.sv
// An allocate searches the lists from the order of the request up, splits a larger block down
// to that order and marks its frames allocated; it answers out of memory without a search when
// too large, or when no list from the order up holds a block. A free marks the block free, pushes
// it and merges it with each buddy found by walking the list of its order; bad frees answer out
// of range or already free. One request at a time; the next is taken the cycle after the result
// is registered. After reset a clearing pass writes every entry of the frame state and link rams, in_ready low.
`default_nettype none

module buddy_page_allocator_top #(
  parameter int NUM_FRAMES  = bpa_pkg::NUM_FRAMES_DEF,
  parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF,
  parameter int FRAME_BYTES = bpa_pkg::FRAME_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bpa_pkg::bpa_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bpa_pkg::bpa_rsp_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata
);

  bpa_pkg::bpa_ctl_t  ctl;
  bpa_pkg::bpa_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .stat(stat),
    .in_ready(in_ready), .ctl(ctl)
  );

  bpa_dp #(
    .NUM_FRAMES(NUM_FRAMES), .ORDER_COUNT(ORDER_COUNT), .FRAME_BYTES(FRAME_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_ready(out_ready),
    .stat(stat), .out_valid(out_valid), .out_data(out_data)
  );

  // error results carry no block
  a_err_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != bpa_pkg::ST_OK
      |-> out_data.block_frames == '0 && out_data.block_address == '0)
    else $error("error result carries a block");

  a_frames_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_data.block_frames))
    else $error("block frames not a power of two");

  // a taken request keeps the sequencer busy
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

`default_nettype wire
